/* hw/rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define PTP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("port check failed");

// next-cycle implication, sampled on clk, off during rst
`define PTP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("port check failed");

`endif

/* hw/rtl/ptp_pkg.sv */
package ptp_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int PAYLOAD_BITS  = 32;
  localparam int PRIORITY_BITS = 16;
  localparam int STAMP_BITS    = 32;

  localparam logic [2:0] CMD_ADD     = 3'd0;
  localparam logic [2:0] CMD_PROMOTE = 3'd1;
  localparam logic [2:0] CMD_PEEK    = 3'd2;
  localparam logic [2:0] CMD_POP     = 3'd3;
  localparam logic [2:0] CMD_CHECK   = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_BADSLOT = 2'd3;

  typedef struct packed {
    logic [2:0]              command;
    logic [3:0]              slot_id;
    logic [PAYLOAD_BITS-1:0] payload;
  } req_t;

  typedef struct packed {
    logic [1:0]               status;
    logic [3:0]               result_slot;
    logic [PAYLOAD_BITS-1:0]  result_payload;
    logic [PRIORITY_BITS-1:0] result_priority;
    logic                     slot_present;
  } rsp_t;

  typedef struct packed {
    logic [PRIORITY_BITS-1:0] prio;
    logic [STAMP_BITS-1:0]    stamp;
    logic [PAYLOAD_BITS-1:0]  payload;
  } entry_t;

  typedef struct packed {
    logic clear;
    logic sample;
    logic live;
  } best_ctl_t;

endpackage

/* hw/rtl/priority_table_with_promote.sv */
// Priority table of DEPTH slots with add, promote, peek, pop and check
// commands. A command is taken when start is high and busy is low; its one
// result appears for a single cycle with done high and must be captured
// then, as nothing holds it. Add walks the valid bits from slot 0 until it
// finds a free slot or reaches the last one; promote and check of a live
// slot take one entry-memory read, then the write-back or report; an
// invalid slot, a check of a dead slot or an unused code reports with no
// memory read. Peek and pop read every slot through the single read port
// of the entry memory. The result of one command leaves while the next may
// already be taken. Valid bits are flops cleared by reset; the entry memory
// needs no clearing pass.
module priority_table_with_promote #(
  parameter int DEPTH = ptp_pkg::DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  ptp_pkg::req_t request,
  output logic          done,
  output ptp_pkg::rsp_t result
);
  import ptp_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(DEPTH - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ADD   = 3'd1;
  localparam logic [2:0] S_RMW   = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_DRAIN = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]            state, state_next;
  logic [IDX_W-1:0]      idx, idx_next;
  logic [IDX_W-1:0]      op_idx, op_idx_next;
  logic                  pop, pop_next;
  logic                  pend, pend_next;
  logic [IDX_W-1:0]      pend_idx;
  logic                  pend_live;
  req_t                  req_q;
  logic [DEPTH-1:0]      valid;
  logic [STAMP_BITS-1:0] stamp;
  logic                  done_next;
  rsp_t                  result_next;

  logic                  accept;
  logic                  sid_ok;
  logic [IDX_W-1:0]      sid_idx;
  logic                  sid_live;
  logic                  we;
  logic [IDX_W-1:0]      waddr;
  entry_t                wdata;
  logic [IDX_W-1:0]      raddr;
  entry_t                rdata;
  logic                  set_en, clr_en, stamp_inc;
  logic [IDX_W-1:0]      clr_idx;
  best_ctl_t             best_ctl;
  logic                  found;
  logic [IDX_W-1:0]      best_idx;
  entry_t                best_entry;
  logic [PRIORITY_BITS-1:0] prio_up;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign sid_ok   = (32'(request.slot_id) < 32'(DEPTH));
  assign sid_idx  = IDX_W'(request.slot_id);
  assign sid_live = sid_ok && valid[sid_idx];
  assign raddr    = (state == S_SCAN) ? idx : sid_idx;
  assign prio_up  = (&rdata.prio) ? rdata.prio : rdata.prio + 1'b1;

  assign best_ctl.clear  = accept;
  assign best_ctl.sample = pend && (state == S_SCAN || state == S_DRAIN);
  assign best_ctl.live   = pend_live;

  ptp_store #(.DEPTH(DEPTH), .IDX_W(IDX_W)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  ptp_best #(.DEPTH(DEPTH), .IDX_W(IDX_W)) u_best (
    .clk          (clk),
    .rst          (rst),
    .ctl          (best_ctl),
    .sample_idx   (pend_idx),
    .sample_entry (rdata),
    .found        (found),
    .best_idx     (best_idx),
    .best_entry   (best_entry)
  );

  always_comb begin
    state_next  = state;
    idx_next    = idx;
    op_idx_next = op_idx;
    pop_next    = pop;
    pend_next   = 1'b0;
    done_next   = 1'b0;
    result_next = '0;
    we          = 1'b0;
    waddr       = idx;
    wdata       = '0;
    set_en      = 1'b0;
    clr_en      = 1'b0;
    clr_idx     = best_idx;
    stamp_inc   = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (request.command)
            CMD_ADD: begin
              idx_next   = '0;
              state_next = S_ADD;
            end
            CMD_PROMOTE: begin
              if (sid_live) begin
                op_idx_next = sid_idx;
                state_next  = S_RMW;
              end else begin
                done_next               = 1'b1;
                result_next.status      = ST_BADSLOT;
                result_next.result_slot = request.slot_id;
              end
            end
            CMD_PEEK, CMD_POP: begin
              idx_next   = '0;
              pop_next   = (request.command == CMD_POP);
              state_next = S_SCAN;
            end
            CMD_CHECK: begin
              if (sid_live) begin
                op_idx_next = sid_idx;
                state_next  = S_CHECK;
              end else begin
                done_next               = 1'b1;
                result_next.status      = ST_OK;
                result_next.result_slot = request.slot_id;
              end
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end
      S_ADD: begin
        if (!valid[idx]) begin
          we            = 1'b1;
          waddr         = idx;
          wdata.prio    = '0;
          wdata.stamp   = stamp;
          wdata.payload = req_q.payload;
          set_en        = 1'b1;
          stamp_inc     = 1'b1;
          done_next                  = 1'b1;
          result_next.status         = ST_OK;
          result_next.result_slot    = 4'(idx);
          result_next.result_payload = req_q.payload;
          result_next.slot_present   = 1'b1;
          state_next = S_IDLE;
        end else if (idx == LAST) begin
          done_next          = 1'b1;
          result_next.status = ST_FULL;
          state_next         = S_IDLE;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      S_RMW: begin
        we            = 1'b1;
        waddr         = op_idx;
        wdata         = rdata;
        wdata.prio    = prio_up;
        done_next                   = 1'b1;
        result_next.status          = ST_OK;
        result_next.result_slot     = 4'(op_idx);
        result_next.result_payload  = rdata.payload;
        result_next.result_priority = prio_up;
        result_next.slot_present    = 1'b1;
        state_next = S_IDLE;
      end
      S_CHECK: begin
        done_next                   = 1'b1;
        result_next.status          = ST_OK;
        result_next.result_slot     = 4'(op_idx);
        result_next.result_payload  = rdata.payload;
        result_next.result_priority = rdata.prio;
        result_next.slot_present    = 1'b1;
        state_next = S_IDLE;
      end
      S_SCAN: begin
        pend_next = 1'b1;
        if (idx == LAST) begin
          state_next = S_DRAIN;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      S_DRAIN: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        done_next = 1'b1;
        if (!found) begin
          result_next.status = ST_EMPTY;
        end else begin
          clr_en                      = pop;
          clr_idx                     = best_idx;
          result_next.status          = ST_OK;
          result_next.result_slot     = 4'(best_idx);
          result_next.result_payload  = best_entry.payload;
          result_next.result_priority = best_entry.prio;
          result_next.slot_present    = !pop;
        end
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pend  <= 1'b0;
      done  <= 1'b0;
      valid <= '0;
      stamp <= '0;
    end else begin
      state <= state_next;
      pend  <= pend_next;
      done  <= done_next;
      if (set_en) begin
        valid[idx] <= 1'b1;
      end
      if (clr_en) begin
        valid[clr_idx] <= 1'b0;
      end
      if (stamp_inc) begin
        stamp <= stamp + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx       <= idx_next;
    op_idx    <= op_idx_next;
    pop       <= pop_next;
    pend_idx  <= idx;
    pend_live <= valid[idx];
    result    <= result_next;
    if (accept) begin
      req_q <= request;
    end
  end

endmodule

/* hw/rtl/ptp_store.sv */
module ptp_store #(
  parameter int DEPTH = ptp_pkg::DEPTH_DEFAULT,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [IDX_W-1:0]  waddr,
  input  ptp_pkg::entry_t   wdata,
  input  logic [IDX_W-1:0]  raddr,
  output ptp_pkg::entry_t   rdata
);
  import ptp_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/ptp_best.sv */
module ptp_best #(
  parameter int DEPTH = ptp_pkg::DEPTH_DEFAULT,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                rst,
  input  ptp_pkg::best_ctl_t  ctl,
  input  logic [IDX_W-1:0]    sample_idx,
  input  ptp_pkg::entry_t     sample_entry,
  output logic                found,
  output logic [IDX_W-1:0]    best_idx,
  output ptp_pkg::entry_t     best_entry
);
  import ptp_pkg::*;

  logic take;

  assign take = ctl.sample && ctl.live &&
                (!found ||
                 sample_entry.prio > best_entry.prio ||
                 (sample_entry.prio == best_entry.prio &&
                  sample_entry.stamp > best_entry.stamp));

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      found <= 1'b0;
    end else if (take) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_idx   <= sample_idx;
      best_entry <= sample_entry;
    end
  end

endmodule

/* hw/rtl/ptp_checker.sv */
module ptp_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input logic          done,
  input ptp_pkg::req_t request,
  input ptp_pkg::rsp_t result
);
  import ptp_pkg::*;
  `include "assert_macros.svh"

  `PTP_ASSERT_NXT(a_accept_answered, start && !busy, busy || done)
  `PTP_ASSERT_IMP(a_busy_needs_accept, $rose(busy), $past(start))
  `PTP_ASSERT_IMP(a_full_zero, done && result.status == ST_FULL, result.result_slot == 4'd0 && result.result_payload == '0 && !result.slot_present)
  `PTP_ASSERT_IMP(a_empty_zero, done && result.status == ST_EMPTY, result.result_payload == '0 && result.result_priority == '0 && !result.slot_present)
  `PTP_ASSERT_IMP(a_badslot_zero, done && result.status == ST_BADSLOT, result.result_payload == '0 && result.result_priority == '0 && !result.slot_present)

endmodule

bind priority_table_with_promote ptp_checker u_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .done    (done),
  .request (request),
  .result  (result)
);
